// ----- hw/rtl/wmf_pkg.sv -----
// ----------------------------------------------------------------------------
// wmf_pkg: shared types and constants
// Widths, parameter defaults and the controller-to-datapath command struct.
// ----------------------------------------------------------------------------
package wmf_pkg;

    localparam int MAX_NEIGHBORS_DEF = 8;
    localparam int VAL_W             = 32;
    localparam int WGT_W             = 17;
    localparam int LAM_W             = 32;

    typedef struct packed {
        logic insert;
        logic drop;
        logic scan_init;
        logic scan_step;
        logic scan_last;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic scan_done;
    } t_sts;

endpackage

// ----- hw/rtl/wmf_if.sv -----
// ----------------------------------------------------------------------------
// wmf_in_if / wmf_out_if: stream channels
// Valid/ready channels carrying one input beat and one result beat.
// ----------------------------------------------------------------------------
interface wmf_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] neighbor_value;
    logic        [16:0] neighbor_weight;
    logic signed [31:0] center_value;
    logic               last_neighbor;
    modport source (output valid, neighbor_value, neighbor_weight, center_value,
                    last_neighbor, input ready);
    modport sink (input valid, neighbor_value, neighbor_weight, center_value,
                  last_neighbor, output ready);
endinterface

interface wmf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] median_value;
    logic               overflow;
    modport source (output valid, median_value, overflow, input ready);
    modport sink (input valid, median_value, overflow, output ready);
endinterface

// ----- hw/rtl/weighted_median_with_fidelity_unit.sv -----
// Result: registered after the store is scanned, once any previous result has
// been taken by the output.
// Throughput: one neighbor beat per cycle while loading; after the last beat the
// input stays blocked while the store is scanned and the result is handed off.
// Reset: i_rst_n synchronous active low clears state, count, overflow flag, register.
// ----------------------------------------------------------------------------
// weighted_median_with_fidelity_unit: top level
// Weighted median with fidelity term over one pixel's sorted neighbors.
// ----------------------------------------------------------------------------
module weighted_median_with_fidelity_unit
    import wmf_pkg::*;
#(
    parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    wmf_in_if.sink      i_in,
    wmf_out_if.source   o_out
);

    logic [31:0] r_lambda;
    t_cmd        w_cmd;
    t_sts        w_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lambda <= '0;
        end else if (i_cfg_we) begin
            r_lambda <= i_cfg_wdata;
        end
    end

    wmf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_last   (i_in.last_neighbor),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    wmf_dp #(.MAX_NEIGHBORS(MAX_NEIGHBORS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_value    (i_in.neighbor_value),
        .i_weight   (i_in.neighbor_weight),
        .i_center   (i_in.center_value),
        .i_lambda   (r_lambda),
        .o_sts      (w_sts),
        .o_median   (o_out.median_value),
        .o_overflow (o_out.overflow)
    );

`ifndef SYNTH
    a_no_insert_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.full |-> !w_cmd.insert) else $error("insert into full store");
    a_ready_off_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.last_neighbor) |=> !i_in.ready)
        else $error("input taken during scan");
    a_clear_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clear |=> w_sts.empty) else $error("store not cleared");
`endif

endmodule

// ----- hw/rtl/wmf_ctrl.sv -----
// ----------------------------------------------------------------------------
// wmf_ctrl: sequencing controller
// Accepts beats, runs the sort insert, the selection scan and result hand-off.
// ----------------------------------------------------------------------------
module wmf_ctrl
    import wmf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_last,
    output logic o_in_ready,
    input  logic i_out_ready,
    output logic o_out_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {S_LOAD, S_INIT, S_SCAN, S_OUT} t_state;

    t_state r_state;
    t_state n_state;
    logic   r_valid;
    logic   n_valid;

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = r_valid;

    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        o_cmd   = '0;
        if (r_valid && i_out_ready) begin
            n_valid = 1'b0;
        end
        unique case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.insert = !i_sts.full;
                    o_cmd.drop   = i_sts.full;
                    if (i_in_last) begin
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                o_cmd.scan_init = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    o_cmd.scan_step = 1'b0;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_valid || i_out_ready) begin
                    o_cmd.scan_last = 1'b1;
                    o_cmd.clear     = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

endmodule

// ----- hw/rtl/wmf_dp.sv -----
// ----------------------------------------------------------------------------
// wmf_dp: sort store and selection datapath
// Insertion-sorted register store, plus a registered lambda multiply used by
// the fidelity mode and a compare per scan step in both median modes.
// ----------------------------------------------------------------------------
module wmf_dp
    import wmf_pkg::*;
#(
    parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic signed [31:0] i_value,
    input  logic        [16:0] i_weight,
    input  logic signed [31:0] i_center,
    input  logic        [31:0] i_lambda,
    output t_sts               o_sts,
    output logic signed [31:0] o_median,
    output logic               o_overflow
);

    localparam int CNT_W = $clog2(MAX_NEIGHBORS + 1);
    localparam int IDX_W = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int SW    = CNT_W + 1;
    localparam int C_W   = CNT_W + 20;
    localparam int ACC_W = C_W + LAM_W + 1;

    logic signed [31:0]  r_val [MAX_NEIGHBORS];
    logic        [16:0]  r_wgt [MAX_NEIGHBORS];
    logic [CNT_W-1:0]    r_count;
    logic                r_ovf;
    logic signed [31:0]  r_f;
    logic [CNT_W-1:0]    r_i;
    logic                r_phase;
    logic signed [C_W-1:0] r_c;
    logic signed [ACC_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_p0;
    logic signed [SW:0]  r_pos;
    logic signed [31:0]  r_res;
    logic                r_res_ovf;

    logic [IDX_W-1:0]        w_idx;
    logic [IDX_W-1:0]        w_vidx;
    logic signed [31:0]      w_sv;
    logic [16:0]             w_sw;
    logic signed [C_W-1:0]   w_cn;
    logic signed [ACC_W-1:0] w_p1;
    logic signed [ACC_W-1:0] w_m;
    logic signed [SW+1:0]    w_k;
    logic [IDX_W-1:0]        w_kidx;
    logic                    w_fid;

    assign w_fid  = (i_lambda != '0);
    assign w_idx  = r_i[IDX_W-1:0];
    assign w_vidx = IDX_W'(r_i - 1'b1);
    assign w_sv   = r_val[w_vidx];
    assign w_sw   = r_wgt[w_idx];
    assign w_cn   = r_c - C_W'({w_sw, 1'b0});
    assign w_p1   = ACC_W'(r_f) + (r_prod >>> 16);
    assign w_m    = (w_p1 > ACC_W'(w_sv)) ? w_p1 : ACC_W'(w_sv);

    assign o_sts.full      = (r_count == CNT_W'(MAX_NEIGHBORS));
    assign o_sts.empty     = (r_count == '0);
    assign o_sts.scan_done = w_fid ? (r_i == r_count && r_phase)
                                   : (SW'(r_i) == SW'(r_count) + 1'b1);
    assign o_median        = r_res;
    assign o_overflow      = r_res_ovf;

    always_comb begin
        w_k = (SW+2)'((SW+2)'(r_count) + 1'b1 + (SW+2)'(r_pos)) >>> 1;
        if (w_k < 1) begin
            w_k = 1;
        end
        if (w_k > (SW+2)'(r_count)) begin
            w_k = (SW+2)'(r_count);
        end
        w_kidx = IDX_W'(w_k - 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            for (int k = 0; k < MAX_NEIGHBORS; k++) begin
                if (k < r_count) begin
                    if (r_val[k] > i_value) begin
                        if (k + 1 < MAX_NEIGHBORS) begin
                            r_val[k+1] <= r_val[k];
                            r_wgt[k+1] <= r_wgt[k];
                        end
                        if (k == 0 || !(r_val[k-1 < 0 ? 0 : k-1] > i_value)) begin
                            r_val[k] <= i_value;
                            r_wgt[k] <= i_weight;
                        end
                    end
                end else if (k == r_count) begin
                    if (k == 0 || !(r_val[k-1 < 0 ? 0 : k-1] > i_value)) begin
                        r_val[k] <= i_value;
                        r_wgt[k] <= i_weight;
                    end
                end
            end
        end
        if (i_cmd.insert || i_cmd.drop) begin
            r_f <= i_center;
        end
        if (i_cmd.scan_init) begin
            r_i     <= '0;
            r_phase <= 1'b0;
            r_c     <= C_W'(65536);
            r_pos   <= '0;
            r_prod  <= ACC_W'(65536) * $signed({1'b0, i_lambda});
        end else if (i_cmd.scan_step) begin
            if (w_fid) begin
                if (!r_phase) begin
                    if (r_i == '0) begin
                        r_p0 <= w_p1;
                    end else begin
                        r_p0 <= (r_p0 < w_m) ? r_p0 : w_m;
                    end
                    if (r_i != r_count) begin
                        r_c    <= w_cn;
                        r_prod <= ACC_W'(w_cn) * $signed({1'b0, i_lambda});
                    end
                    r_phase <= 1'b1;
                end else begin
                    r_i     <= r_i + 1'b1;
                    r_phase <= 1'b0;
                end
            end else begin
                if (r_c > 0) begin
                    r_pos <= r_pos + 1'b1;
                end else if (r_c < 0) begin
                    r_pos <= r_pos - 1'b1;
                end
                if (r_i != r_count) begin
                    r_c <= w_cn;
                end
                r_i <= r_i + 1'b1;
            end
        end
        if (i_cmd.scan_last) begin
            r_res_ovf <= r_ovf;
            if (r_count == '0) begin
                r_res <= '0;
            end else if (w_fid) begin
                if (r_p0 > ACC_W'(32'sh7fffffff)) begin
                    r_res <= 32'sh7fffffff;
                end else if (r_p0 < -ACC_W'(64'sh80000000)) begin
                    r_res <= 32'sh80000000;
                end else begin
                    r_res <= r_p0[31:0];
                end
            end else begin
                r_res <= r_val[w_kidx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.insert) begin
            r_count <= r_count + 1'b1;
        end else if (i_cmd.drop) begin
            r_ovf <= 1'b1;
        end
    end

endmodule
